// ===== rtl/gpio_masked_io_with_change_fifo_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the GPIO block with change capture ring.
// Assertions are compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef GPIO_MASKED_IO_WITH_CHANGE_FIFO_ASSERT_SVH
`define GPIO_MASKED_IO_WITH_CHANGE_FIFO_ASSERT_SVH

`ifndef SYNTH
`define GMIO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gmio assertion failed");
`define GMIO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gmio assertion failed");
`else
`define GMIO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GMIO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/gmio_pkg.sv =====
// ---------------------------------------------------------------------------
// GPIO change capture package
// Widths, command and status codes, and controller state type.
// ---------------------------------------------------------------------------
package gmio_pkg;

   localparam int RING_DEPTH = 256;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int WORD_W     = 32;
   localparam int SNAP_W     = 2 * WORD_W;
   localparam int CMD_W      = 3;
   localparam int CHAN_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int LEVEL_W    = 8;
   localparam int LEVEL_MAX  = 255;
   localparam int CNT_W      = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;

   localparam logic [CHAN_W-1:0] CHAN_ONE = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_TWO = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_IN     = 3'd0,
      CMD_OUT    = 3'd1,
      CMD_TRI    = 3'd2,
      CMD_SAMPLE = 3'd3,
      CMD_POP    = 3'd4,
      CMD_ODRAIN = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_UNCHANGED = 3'd3,
      ST_BAD       = 3'd4
   } status_type;

   typedef enum logic {
      FS_IDLE  = 1'b0,
      FS_FETCH = 1'b1
   } fsm_type;

endpackage

// ===== rtl/gmio_req_if.sv =====
// ---------------------------------------------------------------------------
// GPIO command channel
// Valid/ready channel carrying one command beat.
// ---------------------------------------------------------------------------
interface gmio_req_if import gmio_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [CHAN_W-1:0]   chan;
   logic [WORD_W-1:0]   mask;
   logic [WORD_W-1:0]   data;
   logic [WORD_W-1:0]   pins_one;
   logic [WORD_W-1:0]   pins_two;

   modport source (output valid, cmd, chan, mask, data, pins_one, pins_two, input ready);
   modport sink   (input valid, cmd, chan, mask, data, pins_one, pins_two, output ready);
endinterface

// ===== rtl/gmio_rsp_if.sv =====
// ---------------------------------------------------------------------------
// GPIO response channel
// Valid/ready channel carrying one response beat.
// ---------------------------------------------------------------------------
interface gmio_rsp_if import gmio_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   read_data;
   logic [SNAP_W-1:0]   fifo_word;
   logic [LEVEL_W-1:0]  fifo_level;

   modport source (output valid, status, read_data, fifo_word, fifo_level, input ready);
   modport sink   (input valid, status, read_data, fifo_word, fifo_level, output ready);
endinterface

// ===== rtl/gmio_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gmio_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gpio_masked_io_with_change_fifo.sv =====
// ---------------------------------------------------------------------------
// Two-channel masked GPIO with change capture ring
// Masked in, out and tristate commands per channel, a sample command that
// pushes changed pin snapshots into a ring memory, and a pop command.
// ---------------------------------------------------------------------------
// An accepted command's result is registered in the res_* registers and then
// moved to the response registers once the output is free; a response beat
// holds while the response side is stalled. A new command is taken only once
// that move is made; it waits on the registered ring read and a free output.
// Reset: synchronous; clears pointers, level, last snapshot, drive values
// and makes every pin an input. The ring memory itself is not cleared.
`include "gpio_masked_io_with_change_fifo_assert.svh"

module gpio_masked_io_with_change_fifo import gmio_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gmio_req_if.sink    req_ch,
   gmio_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   fsm_type               fsm_ff, fsm_in;
   logic                  dual_ff;
   logic [WORD_W-1:0]     drive_ff [2];
   logic [WORD_W-1:0]     drive_in [2];
   logic [WORD_W-1:0]     dir_ff [2];
   logic [WORD_W-1:0]     dir_in [2];
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      held_ff, held_in;
   logic [SNAP_W-1:0]     last_ff, last_in;

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [WORD_W-1:0]     res_read_ff, res_read_in;
   logic [LEVEL_W-1:0]    res_level_ff, res_level_in;
   logic                  res_pop_ff, res_pop_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [WORD_W-1:0]     rsp_read_ff;
   logic [SNAP_W-1:0]     rsp_word_ff;
   logic [LEVEL_W-1:0]    rsp_level_ff;

   logic                  accept;
   logic                  out_free;
   logic                  load_out;
   logic                  chan_ok;
   logic                  ci;
   logic [SNAP_W-1:0]     snap;
   logic                  push;
   logic [SNAP_W-1:0]     ram_rd_data;
   logic [CNT_W-1:0]      held_wide;
   logic                  pop_ok;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign chan_ok  = (req_ch.chan == CHAN_ONE) || ((req_ch.chan == CHAN_TWO) && dual_ff);
   assign ci       = (req_ch.chan == CHAN_TWO);
   assign snap     = {(dual_ff ? req_ch.pins_two : {WORD_W{1'b0}}), req_ch.pins_one};
   assign pop_ok   = accept && (req_ch.cmd == CMD_POP) && (held_ff != '0);

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FS_IDLE: begin
            if (accept) begin
               fsm_in = FS_FETCH;
            end
         end
         FS_FETCH: begin
            if (out_free) begin
               fsm_in = FS_IDLE;
            end
         end
         default: begin
            fsm_in = FS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ch.ready = (fsm_ff == FS_IDLE);
      load_out     = (fsm_ff == FS_FETCH) && out_free;
   end

   always_comb begin
      drive_in      = drive_ff;
      dir_in        = dir_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      held_in       = held_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_pop_in    = res_pop_ff;
      push          = 1'b0;
      if (accept) begin
         res_status_in = ST_OK;
         res_read_in   = '0;
         res_pop_in    = 1'b0;
         case (req_ch.cmd)
            CMD_IN: begin
               if (!chan_ok) begin
                  res_status_in = ST_BAD;
               end else begin
                  dir_in[ci]  = dir_ff[ci] | req_ch.mask;
                  res_read_in = (ci ? req_ch.pins_two : req_ch.pins_one) & req_ch.mask;
               end
            end
            CMD_OUT: begin
               if (!chan_ok) begin
                  res_status_in = ST_BAD;
               end else begin
                  drive_in[ci] = (drive_ff[ci] & ~req_ch.mask) | (req_ch.data & req_ch.mask);
                  dir_in[ci]   = dir_ff[ci] & ~req_ch.mask;
               end
            end
            CMD_TRI: begin
               if (!chan_ok) begin
                  res_status_in = ST_BAD;
               end else begin
                  dir_in[ci] = (dir_ff[ci] & ~req_ch.mask) | (~req_ch.data & req_ch.mask);
               end
            end
            CMD_SAMPLE: begin
               if (snap == last_ff) begin
                  res_status_in = ST_UNCHANGED;
               end else if (held_ff == PTR_W'(RING_DEPTH - 1)) begin
                  res_status_in = ST_DROPPED;
               end else begin
                  push      = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  held_in   = held_ff + 1'b1;
                  last_in   = snap;
               end
            end
            CMD_POP: begin
               if (held_ff == '0) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  res_pop_in = 1'b1;
                  rd_ptr_in  = (rd_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
                  held_in    = held_ff - 1'b1;
               end
            end
            default: begin
               res_status_in = ST_BAD;
            end
         endcase
      end
   end

   assign held_wide    = CNT_W'(held_in);
   assign res_level_in = (held_wide > CNT_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                         : LEVEL_W'(held_wide);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   gmio_ram #(
      .WIDTH (SNAP_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (snap),
      .rd_en   (res_pop_in && accept),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FS_IDLE;
         dual_ff      <= 1'b0;
         drive_ff[0]  <= '0;
         drive_ff[1]  <= '0;
         dir_ff[0]    <= '1;
         dir_ff[1]    <= '1;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         if (csr_wr_en) begin
            dual_ff <= csr_wr_data;
         end
         drive_ff     <= drive_in;
         dir_ff       <= dir_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         held_ff      <= held_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_pop_ff    <= res_pop_in;
      if (accept) begin
         res_level_ff <= res_level_in;
      end
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_word_ff   <= res_pop_ff ? ram_rd_data : '0;
         rsp_level_ff  <= res_level_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_data  = rsp_read_ff;
   assign rsp_ch.fifo_word  = rsp_word_ff;
   assign rsp_ch.fifo_level = rsp_level_ff;

   `GMIO_ASSERT_IMPL(a_held_bound, clock, reset, 1'b1, held_ff <= PTR_W'(RING_DEPTH - 1))
   `GMIO_ASSERT_NEXT(a_accept_fetch, clock, reset, accept, fsm_ff == FS_FETCH)
   `GMIO_ASSERT_NEXT(a_pop_level, clock, reset, pop_ok, held_ff == PTR_W'($past(held_ff) - 1'b1))
   `GMIO_ASSERT_IMPL(a_empty_word, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_word_ff == '0)

endmodule

// ===== sim/gpio_masked_io_with_change_fifo_tb.sv =====
// ---------------------------------------------------------------------------
// Testbench for the two-channel masked GPIO with change capture ring
// A short table of directed commands is followed by random phases that mix
// masked pin commands, samples and pops, and that fill the ring to its limit
// and drain again. Responses are checked against a predictor or a typed row.
// ---------------------------------------------------------------------------
module gpio_masked_io_with_change_fifo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gmio_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RSP_LATENCY   = 2;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 10;
   localparam int MIXED_ITEMS   = 110;
   localparam int FILL_ITEMS    = 270;
   localparam int DRAIN_ITEMS   = 265;
   localparam int DIR_ROWS      = 25;

   localparam logic [CMD_W-1:0]  CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0]  CMD_RSVD7 = 3'd7;
   localparam logic [CHAN_W-1:0] CHAN_NONE = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_BAD  = 2'd3;
   localparam logic [WORD_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] NONE      = 32'h0000_0000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAN_W-1:0] chan;
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] data;
      logic [WORD_W-1:0] pins_one;
      logic [WORD_W-1:0] pins_two;
   } gpio_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   read_data;
      logic [SNAP_W-1:0]   fifo_word;
      logic [LEVEL_W-1:0]  fifo_level;
   } gpio_rsp_type;

   typedef struct packed {
      logic         set_dual;
      logic         dual_val;
      gpio_cmd_type beat;
      logic         typed;
      gpio_rsp_type rsp;
   } dir_row_type;

   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{1'b1, 1'b0, '{CMD_POP, CHAN_ONE, NONE, NONE, NONE, NONE},
        1'b1, '{ST_EMPTY, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_SAMPLE, CHAN_ONE, NONE, NONE, NONE, NONE},
        1'b1, '{ST_UNCHANGED, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_IN, CHAN_ONE, ALL_ONES, NONE, ALL_ONES, NONE},
        1'b1, '{ST_OK, ALL_ONES, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_IN, CHAN_TWO, ALL_ONES, NONE, ALL_ONES, ALL_ONES},
        1'b1, '{ST_BAD, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_OUT, CHAN_NONE, ALL_ONES, ALL_ONES, NONE, NONE},
        1'b1, '{ST_BAD, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_TRI, CHAN_BAD, ALL_ONES, NONE, NONE, NONE},
        1'b1, '{ST_BAD, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_ODRAIN, CHAN_ONE, ALL_ONES, ALL_ONES, NONE, NONE},
        1'b1, '{ST_BAD, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_RSVD6, CHAN_ONE, ALL_ONES, NONE, ALL_ONES, NONE},
        1'b1, '{ST_BAD, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_RSVD7, CHAN_ONE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
        1'b1, '{ST_BAD, NONE, 64'd0, 8'd0}},
      '{1'b0, 1'b0, '{CMD_OUT, CHAN_ONE, ALL_ONES, 32'hA5A5_5A5A, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_TRI, CHAN_ONE, 32'h0000_FFFF, NONE, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_TRI, CHAN_ONE, 32'hFFFF_0000, ALL_ONES, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_SAMPLE, CHAN_ONE, NONE, NONE, ALL_ONES, 32'h1234_5678},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_SAMPLE, CHAN_ONE, NONE, NONE, ALL_ONES, 32'h1234_5678},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_POP, CHAN_ONE, NONE, NONE, NONE, NONE},
        1'b0, '0},
      '{1'b1, 1'b1, '{CMD_SAMPLE, CHAN_ONE, NONE, NONE, ALL_ONES, ALL_ONES},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_IN, CHAN_TWO, ALL_ONES, NONE, NONE, 32'h8000_0001},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_OUT, CHAN_TWO, NONE, ALL_ONES, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_OUT, CHAN_TWO, ALL_ONES, 32'h8000_0001, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_TRI, CHAN_TWO, ALL_ONES, ALL_ONES, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_IN, CHAN_ONE, NONE, NONE, ALL_ONES, ALL_ONES},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_POP, CHAN_ONE, NONE, NONE, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_POP, CHAN_ONE, NONE, NONE, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_SAMPLE, CHAN_ONE, NONE, NONE, NONE, NONE},
        1'b0, '0},
      '{1'b0, 1'b0, '{CMD_SAMPLE, CHAN_ONE, NONE, NONE, NONE, 32'h0000_0001},
        1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   gmio_req_if req_bus ();
   gmio_rsp_if rsp_bus ();

   gpio_masked_io_with_change_fifo u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic              dual_chan;
   logic [WORD_W-1:0] drive_reg [2];
   logic [WORD_W-1:0] dir_reg [2];
   logic [SNAP_W-1:0] snap_mem [RING_DEPTH];
   int                rd_ptr;
   int                wr_ptr;
   int                held;
   logic [SNAP_W-1:0] last_snap;

   gpio_rsp_type      pending_rsps [$];
   int                fail_count = 0;
   int                idle_pct = 0;
   logic [WORD_W-1:0] walk_one;
   logic [WORD_W-1:0] walk_two;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic gpio_rsp_type apply_gpio_cmd(input gpio_cmd_type b);
      gpio_rsp_type      r;
      logic              chan_ok;
      int                ci;
      logic [SNAP_W-1:0] word;
      r = '0;
      r.status = ST_OK;
      chan_ok = (b.chan == CHAN_ONE) || (b.chan == CHAN_TWO && dual_chan);
      ci = (b.chan == CHAN_TWO) ? 1 : 0;
      case (b.cmd)
         CMD_IN: begin
            if (!chan_ok) begin
               r.status = ST_BAD;
            end else begin
               dir_reg[ci] = dir_reg[ci] | b.mask;
               r.read_data = (ci == 1 ? b.pins_two : b.pins_one) & b.mask;
            end
         end
         CMD_OUT: begin
            if (!chan_ok) begin
               r.status = ST_BAD;
            end else begin
               drive_reg[ci] = (drive_reg[ci] & ~b.mask) | (b.data & b.mask);
               dir_reg[ci] = dir_reg[ci] & ~b.mask;
            end
         end
         CMD_TRI: begin
            if (!chan_ok) begin
               r.status = ST_BAD;
            end else begin
               dir_reg[ci] = (dir_reg[ci] & ~b.mask) | (~b.data & b.mask);
            end
         end
         CMD_SAMPLE: begin
            word = {(dual_chan ? b.pins_two : {WORD_W{1'b0}}), b.pins_one};
            if (word == last_snap) begin
               r.status = ST_UNCHANGED;
            end else if (held >= RING_DEPTH - 1) begin
               r.status = ST_DROPPED;
            end else begin
               snap_mem[wr_ptr] = word;
               wr_ptr = (wr_ptr + 1) % RING_DEPTH;
               held++;
               last_snap = word;
            end
         end
         CMD_POP: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.fifo_word = snap_mem[rd_ptr];
               rd_ptr = (rd_ptr + 1) % RING_DEPTH;
               held--;
            end
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      r.fifo_level = (held > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(held);
      return r;
   endfunction

   function automatic gpio_cmd_type rand_gpio_cmd();
      gpio_cmd_type b;
      int           pick;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: b.mask = NONE;
         1: b.mask = ALL_ONES;
         2: b.mask = WORD_W'(1) << $urandom_range(WORD_W - 1);
         default: b.mask = $urandom();
      endcase
      b.data = $urandom();
      if ($urandom_range(9) == 0) begin
         b.chan = CHAN_W'($urandom_range(3));
      end else begin
         b.chan = $urandom_range(1) ? CHAN_ONE : CHAN_TWO;
      end
      if ($urandom_range(2) == 0) begin
         walk_one = $urandom();
      end
      if ($urandom_range(2) == 0) begin
         walk_two = $urandom();
      end
      b.pins_one = walk_one;
      b.pins_two = walk_two;
      if (pick < 15) begin
         b.cmd = CMD_IN;
      end else if (pick < 30) begin
         b.cmd = CMD_OUT;
      end else if (pick < 45) begin
         b.cmd = CMD_TRI;
      end else if (pick < 72) begin
         b.cmd = CMD_SAMPLE;
      end else if (pick < 94) begin
         b.cmd = CMD_POP;
      end else begin
         b.cmd = CMD_W'($urandom_range(7, 5));
      end
      return b;
   endfunction

   task automatic push_beat(input gpio_cmd_type b, input logic typed,
                            input gpio_rsp_type typed_rsp);
      gpio_rsp_type predicted;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= b.cmd;
      req_bus.chan     <= b.chan;
      req_bus.mask     <= b.mask;
      req_bus.data     <= b.data;
      req_bus.pins_one <= b.pins_one;
      req_bus.pins_two <= b.pins_two;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = apply_gpio_cmd(b);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic set_dual_chan(input logic v);
      req_bus.valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (RSP_LATENCY + 2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      dual_chan = v;
   endtask

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rsp_bus.ready <= 1'b0;
            stall = $urandom_range(10, 1) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      gpio_rsp_type exp_rsp;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            $error("response beat with no command pending");
            fail_count++;
         end else begin
            exp_rsp = pending_rsps.pop_front();
            if (rsp_bus.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.read_data !== exp_rsp.read_data) begin
               $error("read_data: expected %h, got %h", exp_rsp.read_data, rsp_bus.read_data);
               fail_count++;
            end
            if (rsp_bus.fifo_word !== exp_rsp.fifo_word) begin
               $error("fifo_word: expected %h, got %h", exp_rsp.fifo_word, rsp_bus.fifo_word);
               fail_count++;
            end
            if (rsp_bus.fifo_level !== exp_rsp.fifo_level) begin
               $error("fifo_level: expected %0d, got %0d",
                      exp_rsp.fifo_level, rsp_bus.fifo_level);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      gpio_cmd_type      b;
      logic [WORD_W-1:0] fill_base;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = '0;
      req_bus.chan     = '0;
      req_bus.mask     = '0;
      req_bus.data     = '0;
      req_bus.pins_one = '0;
      req_bus.pins_two = '0;
      dual_chan        = 1'b0;
      drive_reg        = '{NONE, NONE};
      dir_reg          = '{ALL_ONES, ALL_ONES};
      rd_ptr           = 0;
      wr_ptr           = 0;
      held             = 0;
      last_snap        = '0;
      walk_one         = '0;
      walk_two         = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIR_TAB[i].set_dual) begin
            set_dual_chan(DIR_TAB[i].dual_val);
         end
         push_beat(DIR_TAB[i].beat, DIR_TAB[i].typed, DIR_TAB[i].rsp);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         idle_pct = (phase == 3 || phase == PHASES - 1) ? 0 : ((phase % 2) ? 10 : 25);
         set_dual_chan(phase % 2 == 0);
         if (phase == 2 || phase == 5) begin
            fill_base = $urandom();
            for (int i = 0; i < FILL_ITEMS; i++) begin
               b = rand_gpio_cmd();
               b.cmd = CMD_SAMPLE;
               b.pins_one = fill_base + WORD_W'(i);
               b.pins_two = $urandom();
               push_beat(b, 1'b0, '0);
            end
            for (int i = 0; i < DRAIN_ITEMS; i++) begin
               b = rand_gpio_cmd();
               b.cmd = CMD_POP;
               push_beat(b, 1'b0, '0);
            end
         end else begin
            for (int i = 0; i < MIXED_ITEMS; i++) begin
               push_beat(rand_gpio_cmd(), 1'b0, '0);
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
